### rtl/ordt_pkg.sv
// ----------------------------------------------------------------------------
// Ordered array table package
// Request modes, result status codes and the control state encoding of the
// table, and the per-cell commands shared by the table and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ordt_pkg;

    // Request modes carried in the low bits of the input tdata.
    localparam logic [2:0] MODE_APPEND    = 3'd0;
    localparam logic [2:0] MODE_INSERT    = 3'd1;
    localparam logic [2:0] MODE_OVERWRITE = 3'd2;
    localparam logic [2:0] MODE_DELETE    = 3'd3;
    localparam logic [2:0] MODE_READ      = 3'd4;
    localparam logic [2:0] MODE_SEARCH    = 3'd5;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_BAD_POS   = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } t_status;

    // Command broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_DELETE = 2'd3
    } t_cell_op;

    // Control states of the table.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Capacity limit after reset.
    localparam logic [4:0] CAP_RESET = 5'd16;

    // Packed payload widths, padded to whole bytes.
    localparam int IN_BITS  = 40;
    localparam int OUT_BITS = 48;

endpackage : ordt_pkg

`default_nettype wire

### rtl/ordt_cell.sv
// ----------------------------------------------------------------------------
// Ordered array table cell
// Holds one table entry. Loads a new value, takes its lower neighbor's value
// on insert or its upper neighbor's value on delete, and compares its entry
// against the search key.
// ----------------------------------------------------------------------------
`default_nettype none

module ordt_cell #(
    parameter int IDX   = 0,
    parameter int WIDTH = 32,
    parameter int XW    = 5
) (
    input  wire                     i_clk,
    input  wire                     i_en,
    input  wire ordt_pkg::t_cell_op i_op,
    input  wire [XW-1:0]            i_pos,
    input  wire [XW-1:0]            i_cnt,
    input  wire [WIDTH-1:0]         i_value,
    input  wire [WIDTH-1:0]         i_prev,
    input  wire [WIDTH-1:0]         i_next,
    output logic [WIDTH-1:0]        o_value,
    output logic                    o_match
);
    import ordt_pkg::*;

    localparam logic [XW-1:0] IDX_X  = XW'(IDX);
    localparam logic [XW-1:0] IDX_X1 = XW'(IDX + 1);

    logic [WIDTH-1:0] r_value;
    logic [WIDTH-1:0] n_value;
    logic             w_load;

    // Decide this cell's next entry from the broadcast command.
    always_comb begin
        n_value = r_value;
        w_load  = 1'b0;
        unique case (i_op)
            CELL_HOLD: begin
                w_load = 1'b0;
            end
            CELL_WRITE: begin
                if (IDX_X == i_pos) begin
                    n_value = i_value;
                    w_load  = 1'b1;
                end
            end
            CELL_INSERT: begin
                if (IDX_X == i_pos) begin
                    n_value = i_value;
                    w_load  = 1'b1;
                end else if ((IDX_X > i_pos) && (IDX_X <= i_cnt)) begin
                    n_value = i_prev;
                    w_load  = 1'b1;
                end
            end
            CELL_DELETE: begin
                if ((IDX_X >= i_pos) && (IDX_X1 < i_cnt)) begin
                    n_value = i_next;
                    w_load  = 1'b1;
                end
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    // Entry register; its content only counts below the fill count.
    always_ff @(posedge i_clk) begin
        if (i_en && w_load) begin
            r_value <= n_value;
        end
    end

    // Key compare, limited to entries in use.
    assign o_value = r_value;
    assign o_match = (r_value == i_value) && (IDX_X < i_cnt);

endmodule : ordt_cell

`default_nettype wire

### rtl/ordt_find.sv
// ----------------------------------------------------------------------------
// Ordered array table match encoder
// Reduces the per-cell match flags to a hit flag and the lowest matching
// position.
// ----------------------------------------------------------------------------
`default_nettype none

module ordt_find #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire [DEPTH-1:0] i_match,
    output logic            o_hit,
    output logic [AW-1:0]   o_index
);

    // Scan from the top so that the lowest match wins.
    always_comb begin
        o_index = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                o_index = AW'(i);
            end
        end
    end

    assign o_hit = |i_match;

endmodule : ordt_find

`default_nettype wire

### rtl/ordered_array_table.sv
// ----------------------------------------------------------------------------
// Ordered array table
// Dense ordered table of entries kept in a chain of cells, with append,
// insert, overwrite, delete, read and search requests.
// ----------------------------------------------------------------------------
// Each request is registered in its transfer cycle, and an execute cycle
// then updates all cells at once (each cell loads, or takes its neighbor's
// entry for an insert or delete shift) while the per-cell compares and the
// match encoder resolve a search. The result goes to an output
// register, and the next request is taken while it waits; the execute cycle
// stalls only while the previous result has not been taken. Configuration
// writes of the capacity limit are taken at any time but belong to idle
// periods. The table holds its entries without reset; entries above the fill
// count are never returned.
`default_nettype none

module ordered_array_table #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Capacity limit write channel.
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [4:0]                    i_cfg_data,
    // Requests. tdata: mode[2:0], position[6:3], value_in[38:7], zero[39].
    input  wire                          i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  wire [ordt_pkg::IN_BITS-1:0]  i_s_axis_tdata,
    // Results. tdata: status[1:0], value_out[33:2], found_position[37:34],
    // entry_count[42:38], is_empty[43], is_full[44], zero[47:45].
    output logic                         o_m_axis_tvalid,
    input  wire                          i_m_axis_tready,
    output logic [ordt_pkg::OUT_BITS-1:0] o_m_axis_tdata
);
    import ordt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 5) ? CW : 5;
    localparam int AW = $clog2(DEPTH);
    localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

    // Control and configuration registers.
    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic [4:0]    r_cap;
    logic          r_m_valid;

    // Request and result payload registers.
    logic [2:0]          r_mode;
    logic [3:0]          r_pos;
    logic [31:0]         r_val;
    logic [OUT_BITS-1:0] r_m_data;

    // Execute cycle signals.
    logic              w_in_xfer;
    logic              w_exec_go;
    logic [XW-1:0]     w_cap;
    logic [XW-1:0]     w_cnt;
    logic [XW-1:0]     w_pos;
    logic [XW-1:0]     w_cell_pos;
    logic [XW-1:0]     w_new_cnt;
    t_cell_op          w_op;
    t_status           w_status;
    logic [WIDTH-1:0]  w_key;
    logic [WIDTH-1:0]  w_rd;
    logic [3:0]        w_found;
    logic              w_hit;
    logic [AW-1:0]     w_hit_idx;
    logic [DEPTH-1:0]  w_match;
    logic [WIDTH-1:0]  w_cell_value [DEPTH];
    logic [OUT_BITS-1:0] w_result;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    assign w_in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign w_exec_go = (r_state == ST_EXEC) && (!r_m_valid || i_m_axis_tready);

    // Effective capacity: zero acts as one, anything above the depth as the depth.
    always_comb begin
        w_cap = (r_cap == 5'd0) ? XW'(5'd1) : XW'(r_cap);
        if (w_cap > DEPTH_X) begin
            w_cap = DEPTH_X;
        end
    end

    assign w_cnt = XW'(r_cnt);
    assign w_pos = XW'(r_pos);
    assign w_key = WIDTH'(r_val);

    // Chain of entry cells.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WIDTH-1:0] w_prev;
        logic [WIDTH-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_lo
            assign w_prev = w_cell_value[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_hi
            assign w_next = w_cell_value[g+1];
        end

        ordt_cell #(
            .IDX   (g),
            .WIDTH (WIDTH),
            .XW    (XW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_en    (w_exec_go),
            .i_op    (w_op),
            .i_pos   (w_cell_pos),
            .i_cnt   (w_cnt),
            .i_value (w_key),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_value (w_cell_value[g]),
            .o_match (w_match[g])
        );
    end

    ordt_find #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_find (
        .i_match (w_match),
        .o_hit   (w_hit),
        .o_index (w_hit_idx)
    );

    // Request decode: cell command, status, new count and read data.
    always_comb begin
        w_op       = CELL_HOLD;
        w_cell_pos = w_pos;
        w_status   = STATUS_OK;
        w_new_cnt  = w_cnt;
        w_rd       = '0;
        w_found    = 4'd0;
        unique case (r_mode)
            MODE_APPEND: begin
                if (w_cnt >= w_cap) begin
                    w_status = STATUS_OVERFLOW;
                end else begin
                    w_op       = CELL_WRITE;
                    w_cell_pos = w_cnt;
                    w_new_cnt  = w_cnt + XW'(1);
                end
            end
            MODE_INSERT: begin
                if (w_cnt >= w_cap) begin
                    w_status = STATUS_OVERFLOW;
                end else if ((w_pos > w_cnt) || (w_pos >= DEPTH_X)) begin
                    w_status = STATUS_BAD_POS;
                end else begin
                    w_op      = CELL_INSERT;
                    w_new_cnt = w_cnt + XW'(1);
                end
            end
            MODE_OVERWRITE: begin
                if (w_pos >= w_cnt) begin
                    w_status = STATUS_BAD_POS;
                end else begin
                    w_op = CELL_WRITE;
                end
            end
            MODE_DELETE: begin
                if (w_pos >= w_cnt) begin
                    w_status = STATUS_BAD_POS;
                end else begin
                    w_op      = CELL_DELETE;
                    w_new_cnt = w_cnt - XW'(1);
                end
            end
            MODE_READ: begin
                if (w_pos >= w_cnt) begin
                    w_status = STATUS_BAD_POS;
                end else begin
                    w_rd = w_cell_value[AW'(r_pos)];
                end
            end
            MODE_SEARCH: begin
                if (w_hit) begin
                    w_found = 4'(w_hit_idx);
                end else begin
                    w_status = STATUS_NOT_FOUND;
                end
            end
            default: begin
                w_op = CELL_HOLD;
            end
        endcase
    end

    // Result packing, highest field first.
    assign w_result = {
        3'b000,
        (w_new_cnt >= w_cap),
        (w_new_cnt == '0),
        5'(w_new_cnt),
        w_found,
        32'(w_rd),
        w_status
    };

    // Next state: an execute state per request, held while the output is busy.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_exec_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_cap     <= CAP_RESET;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (w_exec_go) begin
                r_cnt     <= CW'(w_new_cnt);
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_mode <= i_s_axis_tdata[2:0];
            r_pos  <= i_s_axis_tdata[6:3];
            r_val  <= i_s_axis_tdata[38:7];
        end
        if (w_exec_go) begin
            r_m_data <= w_result;
        end
    end

    // A successful append grows the table by exactly one entry.
    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec_go && (r_mode == MODE_APPEND) && (w_status == STATUS_OK))
        |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("append did not raise the entry count by one");

    // An overflow leaves the entry count unchanged.
    a_overflow_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec_go && (w_status == STATUS_OVERFLOW))
        |=> (r_cnt == $past(r_cnt)))
        else $error("overflow changed the entry count");

    // An accepted request blocks the input until it has executed.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !o_s_axis_tready)
        else $error("second request taken before execution");

    // Each execute cycle leaves a valid result behind.
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec_go |=> o_m_axis_tvalid)
        else $error("execute cycle produced no result");

    // The fill count never exceeds the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> (w_cnt <= DEPTH_X))
        else $error("entry count above table depth");

endmodule : ordered_array_table

`default_nettype wire

### tb/tb_ordered_array_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array table testbench
// Drives table requests and capacity limit writes into the table, predicts
// every result with a behavioral copy of the table, and compares each result
// transfer field by field under varying source gaps and sink backpressure.
// ----------------------------------------------------------------------------
module tb_ordered_array_table;

    import ordt_pkg::*;

    // Modes that the table does not define; they must leave it untouched.
    localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

    localparam int TABLE_DEPTH  = 16;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;

    // Result word, laid out as the output tdata from the top bit down.
    typedef struct packed {
        logic [2:0]  pad;
        logic        full;
        logic        empty;
        logic [4:0]  count;
        logic [3:0]  found;
        logic [31:0] read_value;
        t_status     status;
    } t_table_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [4:0]          i_cfg_data = '0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [IN_BITS-1:0]  i_s_axis_tdata = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] o_m_axis_tdata;

    // Shadow copy of the table contents and its settings.
    logic [31:0]   shadow_entries [TABLE_DEPTH];
    int            shadow_fill;
    logic [4:0]    shadow_capacity;
    t_table_result expected_results [$];

    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit filling = 1'b1;

    ordered_array_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run limit; a hang ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Sink backpressure at the rate of the current phase.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // A limit of zero behaves as one, anything above the depth as the depth.
    function automatic int usable_capacity();
        int cap;
        cap = int'(shadow_capacity);
        if (cap == 0) cap = 1;
        if (cap > TABLE_DEPTH) cap = TABLE_DEPTH;
        return cap;
    endfunction

    // Applies one request to the shadow table and returns its result.
    function automatic t_table_result apply_request(input logic [2:0] mode,
                                                    input logic [3:0] pos,
                                                    input logic [31:0] value);
        t_table_result res;
        int cap;
        int i;
        res = '0;
        res.status = STATUS_OK;
        cap = usable_capacity();
        case (mode)
            MODE_APPEND: begin
                if (shadow_fill >= cap) begin
                    res.status = STATUS_OVERFLOW;
                end else begin
                    shadow_entries[shadow_fill] = value;
                    shadow_fill++;
                end
            end
            MODE_INSERT: begin
                // Overflow takes precedence over a bad position.
                if (shadow_fill >= cap) begin
                    res.status = STATUS_OVERFLOW;
                end else if (int'(pos) > shadow_fill) begin
                    res.status = STATUS_BAD_POS;
                end else begin
                    for (i = shadow_fill; i > int'(pos); i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[pos] = value;
                    shadow_fill++;
                end
            end
            MODE_OVERWRITE: begin
                if (int'(pos) >= shadow_fill) res.status = STATUS_BAD_POS;
                else shadow_entries[pos] = value;
            end
            MODE_DELETE: begin
                if (int'(pos) >= shadow_fill) begin
                    res.status = STATUS_BAD_POS;
                end else begin
                    for (i = int'(pos); i + 1 < shadow_fill; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_fill--;
                end
            end
            MODE_READ: begin
                if (int'(pos) >= shadow_fill) res.status = STATUS_BAD_POS;
                else res.read_value = shadow_entries[pos];
            end
            MODE_SEARCH: begin
                // Lowest matching position wins.
                res.status = STATUS_NOT_FOUND;
                for (i = 0; i < shadow_fill; i++) begin
                    if (res.status == STATUS_NOT_FOUND && shadow_entries[i] == value) begin
                        res.status = STATUS_OK;
                        res.found = i[3:0];
                    end
                end
            end
            default: ;
        endcase
        res.count = shadow_fill[4:0];
        res.empty = (shadow_fill == 0);
        res.full  = (shadow_fill >= usable_capacity());
        return res;
    endfunction

    task automatic compare_field(input string field_name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field_name, want, got);
            error_count++;
        end
    endtask

    // Compares every result transfer with the oldest prediction.
    always @(posedge i_clk) begin : result_checker
        t_table_result want;
        t_table_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h",
                         $time, o_m_axis_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("status", want.status, got.status);
                compare_field("value_out", want.read_value, got.read_value);
                compare_field("found_position", want.found, got.found);
                compare_field("entry_count", want.count, got.count);
                compare_field("is_empty", want.empty, got.empty);
                compare_field("is_full", want.full, got.full);
                compare_field("padding", want.pad, got.pad);
            end
        end
    end

    // Sends one request, with random source gaps ahead of it.
    task automatic send_request(input logic [2:0] mode, input logic [3:0] pos,
                                input logic [31:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, value, pos, mode};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_results.push_back(apply_request(mode, pos, value));
    endtask

    // Stops the request stream and waits for every result to drain.
    task automatic wait_for_drain();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Capacity limit writes happen only on an idle table.
    task automatic write_capacity(input logic [4:0] limit);
        wait_for_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= limit;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_capacity = limit;
        i_cfg_valid <= 1'b0;
    endtask

    // Every mode on an empty and a small table, including bad positions,
    // insert at the end, duplicate values and the undefined modes.
    task automatic test_basic_requests();
        send_request(MODE_READ, 4'd0, 32'h0);
        send_request(MODE_DELETE, 4'd0, 32'h0);
        send_request(MODE_OVERWRITE, 4'd0, 32'h1);
        send_request(MODE_SEARCH, 4'd0, 32'h0);
        send_request(MODE_INSERT, 4'd1, 32'h7);
        send_request(MODE_INSERT, 4'd0, 32'h0);
        send_request(MODE_APPEND, 4'd15, 32'hFFFF_FFFF);
        send_request(MODE_INSERT, 4'd2, 32'h1234_5678);
        send_request(MODE_INSERT, 4'd1, 32'hFFFF_FFFF);
        send_request(MODE_SEARCH, 4'd0, 32'hFFFF_FFFF);
        send_request(MODE_OVERWRITE, 4'd3, 32'hA5A5_5A5A);
        send_request(MODE_READ, 4'd3, 32'h0);
        send_request(MODE_READ, 4'd15, 32'h0);
        send_request(MODE_DELETE, 4'd1, 32'h0);
        send_request(MODE_DELETE, 4'd2, 32'h0);
        send_request(MODE_UNUSED_6, 4'd9, 32'h8000_0001);
        send_request(MODE_UNUSED_7, 4'd15, $urandom);
        send_request(MODE_SEARCH, 4'd0, 32'hDEAD_BEEF);
        send_request(MODE_READ, 4'd0, 32'h0);
    endtask

    // Capacity extremes: a limit below the count, one, zero and above depth.
    task automatic test_capacity_limits();
        write_capacity(5'd1);
        send_request(MODE_APPEND, 4'd0, 32'h55);
        send_request(MODE_INSERT, 4'd0, 32'h66);
        send_request(MODE_INSERT, 4'd15, 32'h77);
        send_request(MODE_DELETE, 4'd0, 32'h0);
        send_request(MODE_DELETE, 4'd0, 32'h0);
        send_request(MODE_APPEND, 4'd0, 32'h8000_0000);
        write_capacity(5'd0);
        send_request(MODE_APPEND, 4'd0, 32'h1);
        send_request(MODE_READ, 4'd0, 32'h0);
        write_capacity(5'd31);
        send_request(MODE_APPEND, 4'd0, 32'h2);
    endtask

    // Random traffic that swings the fill level between empty and full.
    task automatic test_random_requests(input int item_total);
        int n;
        int pick;
        int w_app;
        int w_ins;
        int w_del;
        logic [2:0]  mode;
        logic [3:0]  pos;
        logic [31:0] value;
        for (n = 0; n < item_total; n++) begin
            if (shadow_fill >= usable_capacity() && $urandom_range(0, 3) == 0) filling = 1'b0;
            if (shadow_fill == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
            w_app = filling ? 28 : 8;
            w_ins = filling ? 24 : 6;
            w_del = filling ? 8 : 42;
            pick = $urandom_range(0, 99);
            if (pick < 4) mode = $urandom_range(0, 1) ? MODE_UNUSED_7 : MODE_UNUSED_6;
            else if (pick < 4 + w_app) mode = MODE_APPEND;
            else if (pick < 4 + w_app + w_ins) mode = MODE_INSERT;
            else if (pick < 4 + w_app + w_ins + w_del) mode = MODE_DELETE;
            else if (pick < 4 + w_app + w_ins + w_del + 10) mode = MODE_OVERWRITE;
            else if (pick < 4 + w_app + w_ins + w_del + 22) mode = MODE_READ;
            else mode = MODE_SEARCH;

            // Mostly positions near the live range, sometimes anywhere.
            if ($urandom_range(0, 4) != 0) pos = 4'($urandom_range(0, shadow_fill));
            else pos = 4'($urandom_range(0, 15));

            // Small values create duplicates; searches often hit a live entry.
            if (mode == MODE_SEARCH && shadow_fill > 0 && $urandom_range(0, 2) != 0)
                value = shadow_entries[$urandom_range(0, shadow_fill - 1)];
            else if ($urandom_range(0, 3) == 0)
                value = $urandom_range(0, 3);
            else
                value = $urandom;
            send_request(mode, pos, value);
        end
    endtask

    initial begin
        shadow_fill = 0;
        shadow_capacity = CAP_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 8;
        recv_stall_pct = 48;
        test_basic_requests();
        test_capacity_limits();
        write_capacity(5'd16);
        test_random_requests(300);
        write_capacity(5'd5);
        test_random_requests(100);

        send_idle_pct  = 48;
        recv_stall_pct = 8;
        write_capacity(5'd31);
        test_random_requests(250);
        write_capacity(5'd2);
        test_random_requests(100);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_capacity(5'd0);
        test_random_requests(50);
        write_capacity(5'd12);
        test_random_requests(150);
        write_capacity(5'd16);
        test_random_requests(150);

        wait_for_drain();
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
